/* rtl/bspl_pkg.sv */
// ----------------------------------------------------------------------------
// bspl_pkg
// Shared types and constants of the bucketed stable priority list.
// ----------------------------------------------------------------------------
`default_nettype none

package bspl_pkg;

  localparam int unsigned NUM_BUCKETS_DEF  = 128;
  localparam int unsigned BUCKET_DEPTH_DEF = 32;

  localparam int unsigned BUCKET_W = 7;
  localparam int unsigned TIER_W   = 3;
  localparam int unsigned MEMBER_W = 16;

  localparam logic [TIER_W-1:0] TIER_MIN = 3'd1;
  localparam logic [TIER_W-1:0] TIER_MAX = 3'd5;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_LIST = 1'b1;

  typedef struct packed {
    logic [TIER_W-1:0]   tier;
    logic [MEMBER_W-1:0] member;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/bucketed_stable_priority_list.sv */
// ----------------------------------------------------------------------------
// bucketed_stable_priority_list
// Per-bucket lists sorted by tier, stable within a tier, kept in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken on a rising edge with start_i high and busy_o low.
//   An add (func_i = 0) stores tier_i/member_id_i in bucket_i behind every
//   entry of equal or higher tier; it gives no result. A list (func_i = 1)
//   gives a header beat and then one beat per entry, the final one with last_o.
//   Each result beat shows on the result ports for one cycle with strobe_o;
//   the receiver cannot stall, so every beat is taken as it appears.
// Timing:
//   One command at a time. An add walks its bucket from the tail, moving one
//   entry per cycle through the entry RAM read/write ports: busy_o stays high
//   through S_CNT alone when dropped or into an empty bucket, else through
//   S_SHIFT and, if the entry lands at the head, S_PUT as well.
//   A list registers its header in S_CNT and then shows one entry per cycle;
//   busy drops with the last beat.
// Reset:
//   After reset a clearing pass zeroes the count RAM, one bucket a cycle,
//   with busy_o high throughout. Entry RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bucketed_stable_priority_list #(
  parameter int unsigned NUM_BUCKETS  = bspl_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned BUCKET_DEPTH = bspl_pkg::BUCKET_DEPTH_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  output logic                           busy_o,
  input  wire                            func_i,
  input  wire  [bspl_pkg::BUCKET_W-1:0]  bucket_i,
  input  wire  [bspl_pkg::TIER_W-1:0]    tier_i,
  input  wire  [bspl_pkg::MEMBER_W-1:0]  member_id_i,
  output logic                           strobe_o,
  output logic [bspl_pkg::BUCKET_W-1:0]  out_bucket_o,
  output logic                           is_header_o,
  output logic [bspl_pkg::TIER_W-1:0]    out_tier_o,
  output logic [bspl_pkg::MEMBER_W-1:0]  out_member_o,
  output logic                           last_o
);

  import bspl_pkg::*;

  localparam int unsigned BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned CW    = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned DEPTH = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CNT   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_LIST  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [BW-1:0]       clr_q, clr_d;
  logic                func_q;
  logic [BUCKET_W-1:0] bucket_q;
  logic [TIER_W-1:0]   tier_q;
  logic [MEMBER_W-1:0] member_q;
  logic                in_range_q;
  logic [BW-1:0]       bidx_q;
  logic [AW-1:0]       base_q;
  logic [CW-1:0]       n_q, n_d;
  logic [CW-1:0]       idx_q, idx_d;

  logic                accept;
  logic [BW-1:0]       bidx_in;

  // count RAM
  logic [CW-1:0] cnt_mem [NUM_BUCKETS];
  logic [CW-1:0] cnt_rd_q;
  logic          cnt_we;
  logic [BW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;

  // entry RAM
  entry_t        ent_mem [DEPTH];
  entry_t        ent_rd_q;
  logic          ent_we, ent_re;
  logic [AW-1:0] ent_waddr, ent_raddr;
  entry_t        ent_wdata;

  // result register
  logic                strobe_q, strobe_d;
  logic                hdr_q, hdr_d;
  logic [TIER_W-1:0]   otier_q, otier_d;
  logic [MEMBER_W-1:0] omem_q, omem_d;
  logic                last_q, last_d;

  entry_t new_entry;
  logic   tier_ok;

  assign busy_o    = (state_q != S_IDLE);
  assign accept    = start_i && !busy_o;
  assign bidx_in   = BW'(bucket_i);
  assign new_entry = '{tier: tier_q, member: member_q};
  assign tier_ok   = (tier_q >= TIER_MIN) && (tier_q <= TIER_MAX);

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (accept) begin
      cnt_rd_q <= cnt_mem[bidx_in];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd_q <= ent_mem[ent_raddr];
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    n_d       = n_q;
    idx_d     = idx_q;
    cnt_we    = 1'b0;
    cnt_waddr = bidx_q;
    cnt_wdata = n_q + 1'b1;
    ent_we    = 1'b0;
    ent_waddr = base_q + AW'(idx_q + 1'b1);
    ent_wdata = ent_rd_q;
    ent_re    = 1'b0;
    ent_raddr = base_q;
    strobe_d  = 1'b0;
    hdr_d     = 1'b0;
    otier_d   = ent_rd_q.tier;
    omem_d    = ent_rd_q.member;
    last_d    = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        cnt_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == BW'(NUM_BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_CNT;
        end
      end
      S_CNT: begin
        n_d = in_range_q ? cnt_rd_q : '0;
        if (func_q == FUNC_LIST) begin
          strobe_d = 1'b1;
          hdr_d    = 1'b1;
          otier_d  = '0;
          omem_d   = '0;
          last_d   = (n_d == '0);
          if (n_d == '0) begin
            state_d = S_IDLE;
          end else begin
            ent_re    = 1'b1;
            ent_raddr = base_q;
            idx_d     = '0;
            state_d   = S_LIST;
          end
        end else if (!in_range_q || !tier_ok || cnt_rd_q >= CW'(BUCKET_DEPTH)) begin
          state_d = S_IDLE;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rd_q + 1'b1;
          if (cnt_rd_q == '0) begin
            ent_we    = 1'b1;
            ent_waddr = base_q;
            ent_wdata = new_entry;
            state_d   = S_IDLE;
          end else begin
            idx_d     = cnt_rd_q - 1'b1;
            ent_re    = 1'b1;
            ent_raddr = base_q + AW'(idx_d);
            state_d   = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        ent_we    = 1'b1;
        ent_waddr = base_q + AW'(idx_q + 1'b1);
        if (ent_rd_q.tier >= tier_q) begin
          ent_wdata = new_entry;
          state_d   = S_IDLE;
        end else begin
          ent_wdata = ent_rd_q;
          if (idx_q == '0) begin
            state_d = S_PUT;
          end else begin
            idx_d     = idx_q - 1'b1;
            ent_re    = 1'b1;
            ent_raddr = base_q + AW'(idx_d);
          end
        end
      end
      S_PUT: begin
        ent_we    = 1'b1;
        ent_waddr = base_q;
        ent_wdata = new_entry;
        state_d   = S_IDLE;
      end
      S_LIST: begin
        strobe_d = 1'b1;
        last_d   = ((idx_q + 1'b1) == n_q);
        if (last_d) begin
          state_d = S_IDLE;
        end else begin
          idx_d     = idx_q + 1'b1;
          ent_re    = 1'b1;
          ent_raddr = base_q + AW'(idx_d);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q     <= func_i;
      bucket_q   <= bucket_i;
      tier_q     <= tier_i;
      member_q   <= member_id_i;
      in_range_q <= (32'(bucket_i) < NUM_BUCKETS);
      bidx_q     <= bidx_in;
      base_q     <= AW'(32'(bidx_in) * BUCKET_DEPTH);
    end
    n_q     <= n_d;
    idx_q   <= idx_d;
    hdr_q   <= hdr_d;
    otier_q <= otier_d;
    omem_q  <= omem_d;
    last_q  <= last_d;
  end

  assign strobe_o     = strobe_q;
  assign out_bucket_o = bucket_q;
  assign is_header_o  = hdr_q;
  assign out_tier_o   = otier_q;
  assign out_member_o = omem_q;
  assign last_o       = last_q;

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy_o))
    else $error("result beat without a command in flight");

  a_list_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o && !is_header_o)
    else $error("listing burst broken");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |=> !strobe_o)
    else $error("beat right after last");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("command beat did not raise busy");

endmodule

`default_nettype wire
